@@ sv/bba_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buddy block allocator package
// Shared constants, entry encoding and controller/datapath command types.
// ---------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned MAX_ORDER   = 16;
  localparam int unsigned UNIT_W      = MAX_ORDER - 1;
  localparam int unsigned TABLE_DEPTH = 1 << UNIT_W;
  localparam int unsigned ORD_W       = 5;
  localparam int unsigned ENT_W       = 7;
  localparam int unsigned SCAN_W      = UNIT_W + 1;
  localparam int unsigned NEED_W      = 33;
  localparam int unsigned BYTES_W     = 17;

  localparam int unsigned ENT_HEAD_BIT = 6;
  localparam int unsigned ENT_USED_BIT = 5;

  localparam logic [1:0] CFG_BASE   = 2'd0;
  localparam logic [1:0] CFG_ORDER  = 2'd1;
  localparam logic [1:0] CFG_HEADER = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_RD,
    OP_SCAN_EV,
    OP_SPLIT_INIT,
    OP_SPLIT,
    OP_MARK,
    OP_FREE_RD,
    OP_FREE_CHK,
    OP_BUD_RD,
    OP_BUD_CLR,
    OP_U_CLR,
    OP_FREE_WR,
    OP_OUT_BAD,
    OP_OUT_NOFIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clearing;
    logic out_busy;
    logic zero_req;
    logic scan_last;
    logic found;
    logic can_split;
    logic free_bad;
    logic entry_ok;
    logic merge_more;
    logic bud_free;
  } dp_stat_t;

  function automatic logic [ENT_W-1:0] make_ent(logic used, logic [ORD_W-1:0] ordm1);
    make_ent = {1'b1, used, ordm1};
  endfunction

endpackage

@@ sv/bba_req_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate or free request word.
// ---------------------------------------------------------------------------
interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] request_bytes;
  logic [31:0] free_address;

  modport source (output valid, req_type, request_bytes, free_address, input ready);
  modport sink   (input valid, req_type, request_bytes, free_address, output ready);
endinterface

@@ sv/bba_rsp_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word per request.
// ---------------------------------------------------------------------------
interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] address;
  logic [16:0] block_bytes;

  modport source (output valid, status, address, block_bytes, input ready);
  modport sink   (input valid, status, address, block_bytes, output ready);
endinterface

@@ sv/bba_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buddy allocator datapath
// Order table memory, configuration, scan/split/merge registers, result word.
// ---------------------------------------------------------------------------
module bba_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 req_type_i,
  input  logic [31:0]          request_bytes_i,
  input  logic [31:0]          free_address_i,
  input  bba_pkg::dp_cmd_t     cmd_i,
  output bba_pkg::dp_stat_t    stat_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [1:0]           status_o,
  output logic [31:0]          address_o,
  output logic [16:0]          block_bytes_o
);

  localparam int unsigned UW = bba_pkg::UNIT_W;
  localparam int unsigned OW = bba_pkg::ORD_W;

  logic [31:0] base_q;
  logic [4:0]  po_q;
  logic [6:0]  hdr_q;
  logic        clr_q;
  logic [UW-1:0] clr_cnt_q;

  logic [bba_pkg::SCAN_W-1:0] scan_q;
  logic [UW-1:0] u_q, best_q;
  logic [OW-1:0] ord_q, bord_q;
  logic          found_q, zero_q, bad_q;
  logic [bba_pkg::NEED_W-1:0] need_q;
  logic [bba_pkg::ENT_W-1:0]  rd_q;

  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [31:0] address_q;
  logic [16:0] bytes_q;

  logic [bba_pkg::ENT_W-1:0] mem [bba_pkg::TABLE_DEPTH];

  logic [OW-1:0] eff;
  logic [bba_pkg::SCAN_W-1:0] units, step, scan_nxt;
  logic [UW-1:0] bu;
  logic [OW-1:0] ord_e;
  logic          ev_take;
  logic [31:0]   off;
  logic          out_busy;
  logic          cfg_hit;

  logic                      we;
  logic [UW-1:0]             wa, ra;
  logic [bba_pkg::ENT_W-1:0] wd;

  always_comb begin
    if (po_q < 5'd1) begin
      eff = 5'd1;
    end else if (po_q > 5'(bba_pkg::MAX_ORDER)) begin
      eff = 5'(bba_pkg::MAX_ORDER);
    end else begin
      eff = po_q;
    end
  end

  assign units    = bba_pkg::SCAN_W'(1) << (eff - 5'd1);
  assign step     = rd_q[bba_pkg::ENT_HEAD_BIT] ? (bba_pkg::SCAN_W'(1) << rd_q[OW-1:0])
                                                : bba_pkg::SCAN_W'(1);
  assign scan_nxt = scan_q + step;
  assign bu       = u_q ^ (UW'(1) << (ord_q - 5'd1));
  assign ord_e    = rd_q[OW-1:0] + 5'd1;
  assign ev_take  = rd_q[bba_pkg::ENT_HEAD_BIT] && !rd_q[bba_pkg::ENT_USED_BIT] &&
                    ((bba_pkg::NEED_W'(1) << ord_e) >= need_q) &&
                    (!found_q || ord_e < bord_q);
  assign off      = free_address_i - base_q - 32'(hdr_q);
  assign out_busy = out_valid_q && !out_ready_i;
  assign cfg_hit  = cfg_we_i && (cfg_index_i == bba_pkg::CFG_BASE ||
                                 cfg_index_i == bba_pkg::CFG_ORDER ||
                                 cfg_index_i == bba_pkg::CFG_HEADER);

  always_comb begin
    stat_o.clearing   = clr_q;
    stat_o.out_busy   = out_busy;
    stat_o.zero_req   = zero_q;
    stat_o.scan_last  = scan_nxt >= units;
    stat_o.found      = found_q;
    stat_o.can_split  = (ord_q > 5'd1) &&
                        ((bba_pkg::NEED_W'(1) << (ord_q - 5'd1)) >= need_q);
    stat_o.free_bad   = bad_q;
    stat_o.entry_ok   = rd_q[bba_pkg::ENT_HEAD_BIT] && rd_q[bba_pkg::ENT_USED_BIT];
    stat_o.merge_more = ord_q < eff;
    stat_o.bud_free   = rd_q == bba_pkg::make_ent(1'b0, ord_q - 5'd1);
  end

  // Memory port control. The clearing pass owns the write port.
  always_comb begin
    we = 1'b0;
    wa = u_q;
    wd = '0;
    ra = scan_q[UW-1:0];
    if (clr_q) begin
      we = 1'b1;
      wa = clr_cnt_q;
      wd = (clr_cnt_q == '0) ? bba_pkg::make_ent(1'b0, eff - 5'd1) : '0;
    end else begin
      unique case (cmd_i.op)
        bba_pkg::OP_FREE_RD: ra = u_q;
        bba_pkg::OP_BUD_RD:  ra = bu;
        bba_pkg::OP_SPLIT: begin
          we = 1'b1;
          wa = best_q + (UW'(1) << (ord_q - 5'd2));
          wd = bba_pkg::make_ent(1'b0, ord_q - 5'd2);
        end
        bba_pkg::OP_MARK: begin
          we = 1'b1;
          wa = best_q;
          wd = bba_pkg::make_ent(1'b1, ord_q - 5'd1);
        end
        bba_pkg::OP_BUD_CLR: begin
          we = 1'b1;
          wa = bu;
        end
        bba_pkg::OP_U_CLR: begin
          we = 1'b1;
        end
        bba_pkg::OP_FREE_WR: begin
          we = 1'b1;
          wd = bba_pkg::make_ent(1'b0, ord_q - 5'd1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      po_q      <= 5'd16;
      hdr_q     <= 7'd4;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + UW'(1);
        if (clr_cnt_q == '1) begin
          clr_q <= 1'b0;
        end
      end
      // A write to the base, order or header register forgets all allocations and restarts the clear.
      if (cfg_hit) begin
        clr_q     <= 1'b1;
        clr_cnt_q <= '0;
        unique case (cfg_index_i)
          bba_pkg::CFG_BASE:   base_q <= cfg_wdata_i;
          bba_pkg::CFG_ORDER:  po_q   <= cfg_wdata_i[4:0];
          bba_pkg::CFG_HEADER: hdr_q  <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      bba_pkg::OP_LOAD: begin
        need_q  <= bba_pkg::NEED_W'(request_bytes_i) + bba_pkg::NEED_W'(hdr_q);
        zero_q  <= (request_bytes_i == '0) && !req_type_i;
        found_q <= 1'b0;
        scan_q  <= '0;
        bad_q   <= off[0] || ((off >> eff) != '0);
        u_q     <= off[UW:1];
      end
      bba_pkg::OP_SCAN_EV: begin
        scan_q <= scan_nxt;
        if (ev_take) begin
          found_q <= 1'b1;
          best_q  <= scan_q[UW-1:0];
          bord_q  <= ord_e;
        end
      end
      bba_pkg::OP_SPLIT_INIT: ord_q <= bord_q;
      bba_pkg::OP_SPLIT:      ord_q <= ord_q - 5'd1;
      bba_pkg::OP_FREE_CHK:   ord_q <= ord_e;
      bba_pkg::OP_U_CLR: begin
        if (bu < u_q) begin
          u_q <= bu;
        end
        ord_q <= ord_q + 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == bba_pkg::OP_MARK || cmd_i.op == bba_pkg::OP_FREE_WR ||
                 cmd_i.op == bba_pkg::OP_OUT_BAD || cmd_i.op == bba_pkg::OP_OUT_NOFIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      bba_pkg::OP_MARK: begin
        status_q  <= bba_pkg::ST_OK;
        address_q <= base_q + {16'd0, best_q, 1'b0} + 32'(hdr_q);
        bytes_q   <= 17'(1) << ord_q;
      end
      bba_pkg::OP_FREE_WR: begin
        status_q  <= bba_pkg::ST_OK;
        address_q <= '0;
        bytes_q   <= 17'(1) << ord_q;
      end
      bba_pkg::OP_OUT_BAD: begin
        status_q  <= bba_pkg::ST_BAD;
        address_q <= '0;
        bytes_q   <= '0;
      end
      bba_pkg::OP_OUT_NOFIT: begin
        status_q  <= bba_pkg::ST_NOFIT;
        address_q <= '0;
        bytes_q   <= '0;
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign address_o     = address_q;
  assign block_bytes_o = bytes_q;

  a_split_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == bba_pkg::OP_SPLIT |-> ord_q > 5'd1)
    else $error("split below minimum block");
  a_merge_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == bba_pkg::OP_U_CLR |-> ord_q < eff)
    else $error("merge beyond pool order");
  a_no_work_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> cmd_i.op == bba_pkg::OP_NONE)
    else $error("command issued during clearing pass");

endmodule

@@ sv/bba_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buddy allocator controller
// Sequences scan, split, merge and result commands for the datapath.
// ---------------------------------------------------------------------------
module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  bba_pkg::dp_stat_t stat_i,
  output bba_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_A_RD    = 14'b00000000000010,
    S_A_EV    = 14'b00000000000100,
    S_A_PICK  = 14'b00000000001000,
    S_A_SPLIT = 14'b00000000010000,
    S_A_MARK  = 14'b00000000100000,
    S_F_RD    = 14'b00000001000000,
    S_F_CHK   = 14'b00000010000000,
    S_M_TEST  = 14'b00000100000000,
    S_M_CHK   = 14'b00001000000000,
    S_M_CLRU  = 14'b00010000000000,
    S_F_WR    = 14'b00100000000000,
    S_E_BAD   = 14'b01000000000000,
    S_E_NOFIT = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && !stat_i.clearing;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = bba_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = bba_pkg::OP_LOAD;
          state_d  = req_type_i ? S_F_RD : S_A_RD;
        end
      end
      S_A_RD: begin
        if (stat_i.zero_req) begin
          state_d = S_E_BAD;
        end else begin
          cmd_o.op = bba_pkg::OP_SCAN_RD;
          state_d  = S_A_EV;
        end
      end
      S_A_EV: begin
        cmd_o.op = bba_pkg::OP_SCAN_EV;
        state_d  = stat_i.scan_last ? S_A_PICK : S_A_RD;
      end
      S_A_PICK: begin
        if (!stat_i.found) begin
          state_d = S_E_NOFIT;
        end else begin
          cmd_o.op = bba_pkg::OP_SPLIT_INIT;
          state_d  = S_A_SPLIT;
        end
      end
      S_A_SPLIT: begin
        if (stat_i.can_split) begin
          cmd_o.op = bba_pkg::OP_SPLIT;
        end else begin
          state_d = S_A_MARK;
        end
      end
      S_A_MARK: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = bba_pkg::OP_MARK;
          state_d  = S_IDLE;
        end
      end
      S_F_RD: begin
        if (stat_i.free_bad) begin
          state_d = S_E_BAD;
        end else begin
          cmd_o.op = bba_pkg::OP_FREE_RD;
          state_d  = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (!stat_i.entry_ok) begin
          state_d = S_E_BAD;
        end else begin
          cmd_o.op = bba_pkg::OP_FREE_CHK;
          state_d  = S_M_TEST;
        end
      end
      S_M_TEST: begin
        if (stat_i.merge_more) begin
          cmd_o.op = bba_pkg::OP_BUD_RD;
          state_d  = S_M_CHK;
        end else begin
          state_d = S_F_WR;
        end
      end
      S_M_CHK: begin
        if (stat_i.bud_free) begin
          cmd_o.op = bba_pkg::OP_BUD_CLR;
          state_d  = S_M_CLRU;
        end else begin
          state_d = S_F_WR;
        end
      end
      S_M_CLRU: begin
        cmd_o.op = bba_pkg::OP_U_CLR;
        state_d  = S_M_TEST;
      end
      S_F_WR: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = bba_pkg::OP_FREE_WR;
          state_d  = S_IDLE;
        end
      end
      S_E_BAD: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = bba_pkg::OP_OUT_BAD;
          state_d  = S_IDLE;
        end
      end
      S_E_NOFIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = bba_pkg::OP_OUT_NOFIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted request not started");
  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == bba_pkg::OP_MARK || cmd_o.op == bba_pkg::OP_FREE_WR ||
     cmd_o.op == bba_pkg::OP_OUT_BAD || cmd_o.op == bba_pkg::OP_OUT_NOFIT)
    |-> !stat_i.out_busy)
    else $error("result written over pending word");

endmodule

@@ sv/buddy_block_allocator_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over a power-of-two pool with a per-unit order table.
// ---------------------------------------------------------------------------
// Allocate: one memory read and one evaluation per block visited in the table
//   walk, then a split per split level; the table port sets the rate. Free:
//   read and check, a buddy read, clear and merge per level, final write.
// A request is taken whenever the controller is idle; the result word sits in
//   an output register so a new request may be accepted before it is taken.
// Reset and every base, order or header write start a clearing pass over all
//   32768 entries of the order table, during which no request is accepted.
module buddy_block_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  bba_req_if.sink     req,
  bba_rsp_if.source   rsp,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  bba_pkg::dp_cmd_t  cmd;
  bba_pkg::dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .req_type_i (req.req_type),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bba_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req.req_type),
    .request_bytes_i (req.request_bytes),
    .free_address_i  (req.free_address),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (rsp.ready),
    .out_valid_o     (rsp.valid),
    .status_o        (rsp.status),
    .address_o       (rsp.address),
    .block_bytes_o   (rsp.block_bytes)
  );

endmodule
